// ----- rtl/sbi_pkg.sv -----
// Shared definitions for the segment/box crossing core and its checker.
// Holds the box side codes, pipeline depth and result bus width; no dependencies.
package sbi_pkg;

    // Box sides, also used as indexes into the per-side arrays.
    typedef enum logic [1:0] {
        SIDE_TOP,
        SIDE_RIGHT,
        SIDE_BOTTOM,
        SIDE_LEFT
    } side_t;

    localparam int NUM_SIDES = 4;

    // Number of register stages between the input and the result port.
    localparam int PIPE_DEPTH = 5;

    // Result bus width: the hit flag padded to one byte.
    localparam int M_DATA_W = 8;

endpackage

// ----- rtl/segment_box_intersect_core.sv -----
// Segment versus axis-aligned box crossing test, five register stages.
// A result is offered on the master side once its item has passed through every stage register in order.
// Throughput: one item per cycle while the output is not stalled; up to five items are in flight at once.
// Any stage that is empty accepts a new item, so bubbles close up under a stalled output.
// Reset (aresetn low at a clock edge) empties every stage; data registers are not cleared.
// Depends on sbi_pkg.
module segment_box_intersect_core #(
    parameter int  COORD_BITS = 16,
    localparam int S_DATA_W   = ((8 * COORD_BITS - 2 + 7) / 8) * 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Input channel.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // From bit 0 up: seg_start_x, seg_start_y, seg_end_x, seg_end_y, box_left, box_top
    // (COORD_BITS each, signed), box_width, box_height (COORD_BITS-1 each, unsigned),
    // then zero padding.
    input  logic [S_DATA_W-1:0]         s_tdata,
    // Result channel.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // From bit 0 up: hit, then zero padding.
    output logic [sbi_pkg::M_DATA_W-1:0] m_tdata
);
    import sbi_pkg::*;

    localparam int CB = COORD_BITS;
    // Width of a product that serves as a bound or the middle term.
    localparam int PW = 2 * CB + 3;

    // Field offsets inside s_tdata.
    localparam int OFS_SX = 0;
    localparam int OFS_SY = CB;
    localparam int OFS_EX = 2 * CB;
    localparam int OFS_EY = 3 * CB;
    localparam int OFS_LF = 4 * CB;
    localparam int OFS_TP = 5 * CB;
    localparam int OFS_W  = 6 * CB;
    localparam int OFS_H  = 7 * CB - 1;

    // ------------------------------------------------------------------
    // Flow control. Each stage holds a valid bit and loads whenever it is
    // empty or its content moves on, so a stall at the output only holds
    // back the stages that are actually full.
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] stage_ready;

    always_comb begin
        stage_ready[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        valid_next[0] = stage_ready[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    // ------------------------------------------------------------------
    // Stage 1: unpack, form the right and bottom edges and the segment
    // direction. Both are exact at one more bit than a coordinate.
    // ------------------------------------------------------------------
    logic [CB-1:0] in_sx, in_sy, in_ex, in_ey, in_left, in_top;
    logic [CB-2:0] in_w, in_h;

    assign in_sx   = s_tdata[OFS_SX +: CB];
    assign in_sy   = s_tdata[OFS_SY +: CB];
    assign in_ex   = s_tdata[OFS_EX +: CB];
    assign in_ey   = s_tdata[OFS_EY +: CB];
    assign in_left = s_tdata[OFS_LF +: CB];
    assign in_top  = s_tdata[OFS_TP +: CB];
    assign in_w    = s_tdata[OFS_W +: CB - 1];
    assign in_h    = s_tdata[OFS_H +: CB - 1];

    logic signed [CB-1:0] sx1_reg, sy1_reg, left1_reg, top1_reg;
    logic signed [CB:0]   right1_reg, bottom1_reg, dx1_reg, dy1_reg;
    logic                 wz1_reg, hz1_reg;
    logic signed [CB:0]   right1_next, bottom1_next, dx1_next, dy1_next;

    assign right1_next  = {in_left[CB-1], in_left} + {2'b00, in_w};
    assign bottom1_next = {in_top[CB-1], in_top} + {2'b00, in_h};
    assign dx1_next     = {in_ex[CB-1], in_ex} - {in_sx[CB-1], in_sx};
    assign dy1_next     = {in_ey[CB-1], in_ey} - {in_sy[CB-1], in_sy};

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            sx1_reg     <= in_sx;
            sy1_reg     <= in_sy;
            left1_reg   <= in_left;
            top1_reg    <= in_top;
            right1_reg  <= right1_next;
            bottom1_reg <= bottom1_next;
            dx1_reg     <= dx1_next;
            dy1_reg     <= dy1_next;
            wz1_reg     <= (in_w == '0);
            hz1_reg     <= (in_h == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: offsets of each box side from the segment start, and the
    // magnitude and sign of the direction. Top and bottom offsets are in y,
    // left and right in x; the same four values serve as the along-edge
    // bounds of the perpendicular sides.
    // ------------------------------------------------------------------
    logic signed [CB+1:0] diff2_next [NUM_SIDES];
    logic signed [CB+1:0] diff2_reg  [NUM_SIDES];
    logic signed [CB:0]   ndx1, ndy1;
    logic [CB-1:0]        adx2_next, ady2_next, adx2_reg, ady2_reg;
    logic signed [CB:0]   dx2_reg, dy2_reg;
    logic                 dxz2_reg, dyz2_reg, wz2_reg, hz2_reg;

    assign diff2_next[SIDE_TOP]    = {{2{top1_reg[CB-1]}}, top1_reg}
                                   - {{2{sy1_reg[CB-1]}}, sy1_reg};
    assign diff2_next[SIDE_BOTTOM] = {bottom1_reg[CB], bottom1_reg}
                                   - {{2{sy1_reg[CB-1]}}, sy1_reg};
    assign diff2_next[SIDE_LEFT]   = {{2{left1_reg[CB-1]}}, left1_reg}
                                   - {{2{sx1_reg[CB-1]}}, sx1_reg};
    assign diff2_next[SIDE_RIGHT]  = {right1_reg[CB], right1_reg}
                                   - {{2{sx1_reg[CB-1]}}, sx1_reg};

    // A coordinate difference never reaches the most negative value, so
    // its magnitude fits in a coordinate's width.
    assign ndx1      = -dx1_reg;
    assign ndy1      = -dy1_reg;
    assign adx2_next = dx1_reg[CB] ? ndx1[CB-1:0] : dx1_reg[CB-1:0];
    assign ady2_next = dy1_reg[CB] ? ndy1[CB-1:0] : dy1_reg[CB-1:0];

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            diff2_reg <= diff2_next;
            adx2_reg  <= adx2_next;
            ady2_reg  <= ady2_next;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            dxz2_reg  <= (dx1_reg == '0);
            dyz2_reg  <= (dy1_reg == '0);
            wz2_reg   <= wz1_reg;
            hz2_reg   <= hz1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: per side, flip the crossing offset onto the sign of the
    // direction and check that the crossing lies within the segment.
    // A side is only live if it has length and is not parallel.
    // ------------------------------------------------------------------
    logic [CB-1:0]        dp3_next  [NUM_SIDES];
    logic [CB-1:0]        dp3_reg   [NUM_SIDES];
    logic [NUM_SIDES-1:0] live3_next, live3_reg;
    logic signed [CB+1:0] diff3_reg [NUM_SIDES];
    logic [CB-1:0]        adx3_reg, ady3_reg;
    logic signed [CB:0]   dx3_reg, dy3_reg;

    for (genvar g = 0; g < NUM_SIDES; g++) begin : g_span
        localparam bit HORIZ = (g == SIDE_TOP) || (g == SIDE_BOTTOM);
        logic                 neg;
        logic [CB-1:0]        rabs;
        logic                 par;
        logic                 flat;
        logic signed [CB+1:0] dpn;
        logic                 in_span;

        assign neg     = HORIZ ? dy2_reg[CB] : dx2_reg[CB];
        assign rabs    = HORIZ ? ady2_reg : adx2_reg;
        assign par     = HORIZ ? dyz2_reg : dxz2_reg;
        assign flat    = HORIZ ? wz2_reg : hz2_reg;
        assign dpn     = neg ? -diff2_reg[g] : diff2_reg[g];
        assign in_span = !dpn[CB+1] && (dpn <= $signed({2'b00, rabs}));

        assign dp3_next[g]   = dpn[CB-1:0];
        assign live3_next[g] = in_span && !par && !flat;
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            dp3_reg   <= dp3_next;
            live3_reg <= live3_next;
            diff3_reg <= diff2_reg;
            adx3_reg  <= adx2_reg;
            ady3_reg  <= ady2_reg;
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: products. The crossing position along each side, scaled by
    // the direction magnitude, must fall between the side's two ends scaled
    // the same way. Top and bottom share their x bounds, left and right
    // share their y bounds.
    // ------------------------------------------------------------------
    logic signed [PW-1:0]  mid4_next [NUM_SIDES];
    logic signed [PW-1:0]  mid4_reg  [NUM_SIDES];
    logic signed [PW-1:0]  xlo4_next, xhi4_next, ylo4_next, yhi4_next;
    logic signed [PW-1:0]  xlo4_reg, xhi4_reg, ylo4_reg, yhi4_reg;
    logic [NUM_SIDES-1:0]  live4_reg;

    assign xlo4_next = diff3_reg[SIDE_LEFT]   * $signed({1'b0, ady3_reg});
    assign xhi4_next = diff3_reg[SIDE_RIGHT]  * $signed({1'b0, ady3_reg});
    assign ylo4_next = diff3_reg[SIDE_TOP]    * $signed({1'b0, adx3_reg});
    assign yhi4_next = diff3_reg[SIDE_BOTTOM] * $signed({1'b0, adx3_reg});

    for (genvar g = 0; g < NUM_SIDES; g++) begin : g_mid
        localparam bit HORIZ = (g == SIDE_TOP) || (g == SIDE_BOTTOM);
        logic signed [CB:0]     rq;
        logic signed [2*CB+1:0] prod;

        assign rq           = HORIZ ? dx3_reg : dy3_reg;
        assign prod         = $signed({1'b0, dp3_reg[g]}) * rq;
        assign mid4_next[g] = {prod[2*CB+1], prod};
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            mid4_reg  <= mid4_next;
            xlo4_reg  <= xlo4_next;
            xhi4_reg  <= xhi4_next;
            ylo4_reg  <= ylo4_next;
            yhi4_reg  <= yhi4_next;
            live4_reg <= live3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: bound checks and the final hit flag, held in the output
    // register until the result transfer.
    // ------------------------------------------------------------------
    logic [NUM_SIDES-1:0] side_hit;
    logic                 hit_reg;

    for (genvar g = 0; g < NUM_SIDES; g++) begin : g_cmp
        localparam bit HORIZ = (g == SIDE_TOP) || (g == SIDE_BOTTOM);
        logic signed [PW-1:0] lo_b;
        logic signed [PW-1:0] hi_b;

        assign lo_b        = HORIZ ? xlo4_reg : ylo4_reg;
        assign hi_b        = HORIZ ? xhi4_reg : yhi4_reg;
        assign side_hit[g] = live4_reg[g] && (lo_b <= mid4_reg[g]) && (mid4_reg[g] <= hi_b);
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            hit_reg <= |side_hit;
        end
    end

    assign m_tdata = {{(M_DATA_W - 1){1'b0}}, hit_reg};

endmodule

// ----- rtl/sbi_checker.sv -----
// Port-level checker for segment_box_intersect_core, bound into that module.
// Tracks items in flight from the handshakes; depends on sbi_pkg.
module sbi_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [sbi_pkg::M_DATA_W-1:0] m_tdata
);
    import sbi_pkg::*;

    localparam int CW = $clog2(PIPE_DEPTH + 1);

    logic [CW-1:0] inflight_reg;
    logic [CW-1:0] inflight_next;
    logic          s_xfer;
    logic          m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_xfer && !m_xfer) begin
            inflight_next = inflight_reg + CW'(1);
        end else if (m_xfer && !s_xfer) begin
            inflight_next = inflight_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // No result appears without an item behind it.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> inflight_reg != '0)
        else $error("result offered with nothing in flight");

    // While any stage is free, the input side must take a transfer.
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg < CW'(PIPE_DEPTH) |-> s_tready)
        else $error("input stalled with room in the pipeline");

    // Padding above the hit flag stays zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_DATA_W-1:1] == '0)
        else $error("result padding not zero");

endmodule

bind segment_box_intersect_core sbi_checker u_sbi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
